// ----- hdl/mtsmr_pkg.sv -----
// Shared types, constants and log-add arithmetic for the signal-to-mask ratio block.
package mtsmr_pkg;

   localparam int MAX_MASKERS     = 4;
   localparam int BANDS_DEFAULT   = 32;
   localparam int MASKERS_DEFAULT = 4;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic signed [15:0] DB_M100 = -16'sd25600;
   localparam logic signed [17:0] DB_M120 = -18'sd30720;
   localparam logic signed [17:0] AUD_BIAS = 18'sd2560;
   localparam logic signed [17:0] AUD_SPAN = 18'sd5120;
   localparam logic [10:0] AUD_ONE  = 11'd1024;
   localparam logic [10:0] AUD_HALF = 11'd512;
   // Reciprocal of five in Q16; exact for the numerator range in use.
   localparam logic [13:0] RECIP_FIVE = 14'd13108;

   localparam logic CSR_OFFSET = 1'b0;
   localparam logic CSR_ENABLE = 1'b1;

   localparam logic [9:0] LOGADD_TAB [33] = '{
      10'd771, 10'd650, 10'd544, 10'd452, 10'd373, 10'd305, 10'd249, 10'd202, 10'd164,
      10'd132, 10'd106, 10'd85, 10'd68, 10'd54, 10'd43, 10'd35, 10'd28, 10'd22,
      10'd17, 10'd14, 10'd11, 10'd9, 10'd7, 10'd6, 10'd4, 10'd4, 10'd3, 10'd2,
      10'd2, 10'd1, 10'd1, 10'd1, 10'd1
   };

   typedef struct packed {
      logic                              last;
      logic signed [15:0]                target;
      logic [MAX_MASKERS-1:0][15:0]      th;
      logic [MAX_MASKERS-1:0]            en;
      logic signed [2:0]                 dom;
   } mid_type;

   typedef struct packed {
      logic signed [15:0]                comb;
      logic signed [15:0]                smr;
      logic [10:0]                       aud;
      logic signed [2:0]                 dom;
      logic [MAX_MASKERS-1:0][15:0]      th;
      logic                              frame_done;
      logic [10:0]                       overall;
      logic [5:0]                        critical;
   } rsp_type;

   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // Power-domain sum of two dB values with an interpolated correction term.
   function automatic logic signed [17:0] log_add(input logic signed [17:0] a,
                                                  input logic signed [17:0] b);
      logic signed [17:0] hi;
      logic signed [17:0] lo;
      logic [18:0]        d;
      logic [4:0]         idx;
      logic [9:0]         t0;
      logic [9:0]         t1;
      logic [17:0]        prod;
      logic [9:0]         f;
      hi   = (a > b) ? a : b;
      lo   = (a > b) ? b : a;
      d    = 19'($signed({hi[17], hi}) - $signed({lo[17], lo}));
      idx  = d[12:8];
      t0   = LOGADD_TAB[idx];
      t1   = LOGADD_TAB[6'(idx) + 6'd1];
      prod = 18'(t0 - t1) * 18'(d[7:0]);
      f    = (d[18:13] == 6'd0) ? 10'(t0 - 10'(prod[17:8])) : 10'd0;
      return hi + $signed({8'd0, f});
   endfunction

endpackage

// ----- hdl/masking_threshold_smr_core.sv -----
// Top level of the per-band signal-to-mask ratio block.
//
// Input bands are pushed through req_push while req_full is low; one band may be
// transferred every cycle. Results appear in band order on the rsp_ ports while
// rsp_empty is low and leave with rsp_pop. A transferred band is written into the
// front queue, then passes one log-add stage per masker, one for the ratio, one
// for audibility and the frame totals, and then the result queue. Sustained
// throughput is one band per cycle while the receiver keeps popping, set by the
// one-masker-per-stage log-add pipeline.
// When the receiver stops popping, the result queue fills, the back end holds,
// the front queue fills and req_full rises; nothing is dropped.
// The band numbered NUM_BANDS-1 carries the frame mean audibility and critical
// band count, after which the totals restart from zero.
// The csr_ port writes the offset (index 0) and masker enable bits (index 1);
// write it only while the block is idle. Reset empties both queues, clears the
// frame totals and sets both registers to zero.
module masking_threshold_smr_core import mtsmr_pkg::*; #(
   parameter int NUM_BANDS   = BANDS_DEFAULT,
   parameter int NUM_MASKERS = MASKERS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [4:0]         req_band_index,
   input  logic signed [15:0] req_target_db,
   input  logic signed [15:0] req_masker_level_0,
   input  logic signed [15:0] req_masker_level_1,
   input  logic signed [15:0] req_masker_level_2,
   input  logic signed [15:0] req_masker_level_3,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [15:0] rsp_combined_threshold_db,
   output logic signed [15:0] rsp_smr_db,
   output logic [10:0]        rsp_audibility,
   output logic signed [2:0]  rsp_dominant_masker,
   output logic signed [15:0] rsp_masker_threshold_0,
   output logic signed [15:0] rsp_masker_threshold_1,
   output logic signed [15:0] rsp_masker_threshold_2,
   output logic signed [15:0] rsp_masker_threshold_3,
   output logic               rsp_frame_done,
   output logic [10:0]        rsp_overall_audibility,
   output logic [5:0]         rsp_critical_band_count,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata
);

   logic signed [15:0]           offset_ff;
   logic [MAX_MASKERS-1:0]       enable_ff;
   logic [MAX_MASKERS-1:0][15:0] levels;
   logic                         mid_valid, mid_pop;
   mid_type                      mid_data;
   logic                         rsp_push, out_full;
   rsp_type                      back_data, out_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         enable_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OFFSET: offset_ff <= csr_wdata;
            CSR_ENABLE: enable_ff <= csr_wdata[MAX_MASKERS-1:0];
            default: ;
         endcase
      end
   end

   assign levels = {req_masker_level_3, req_masker_level_2,
                    req_masker_level_1, req_masker_level_0};

   mtsmr_front #(.NUM_BANDS(NUM_BANDS), .NUM_MASKERS(NUM_MASKERS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (req_push),
      .full        (req_full),
      .band_index  (req_band_index),
      .target_db   (req_target_db),
      .levels      (levels),
      .offset_db   (offset_ff),
      .enable_mask (enable_ff),
      .mid_valid   (mid_valid),
      .mid_pop     (mid_pop),
      .mid_data    (mid_data)
   );

   mtsmr_back #(.NUM_BANDS(NUM_BANDS), .NUM_MASKERS(NUM_MASKERS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_valid (mid_valid),
      .mid_data  (mid_data),
      .mid_pop   (mid_pop),
      .rsp_push  (rsp_push),
      .rsp_data  (back_data),
      .rsp_full  (out_full)
   );

   mtsmr_queue #(.DEPTH(QUEUE_DEPTH), .T(rsp_type)) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (back_data),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_data),
      .empty     (rsp_empty)
   );

   assign rsp_combined_threshold_db = out_data.comb;
   assign rsp_smr_db                = out_data.smr;
   assign rsp_audibility            = out_data.aud;
   assign rsp_dominant_masker       = out_data.dom;
   assign rsp_masker_threshold_0    = out_data.th[0];
   assign rsp_masker_threshold_1    = out_data.th[1];
   assign rsp_masker_threshold_2    = out_data.th[2];
   assign rsp_masker_threshold_3    = out_data.th[3];
   assign rsp_frame_done            = out_data.frame_done;
   assign rsp_overall_audibility    = out_data.overall;
   assign rsp_critical_band_count   = out_data.critical;

   a_reset_empties: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_summary_only_on_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_frame_done |->
         rsp_overall_audibility == '0 && rsp_critical_band_count == '0)
      else $error("frame summary on an ordinary band");

   a_audibility_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_audibility <= AUD_ONE && rsp_overall_audibility <= AUD_ONE)
      else $error("audibility above one");

   a_full_blocks_back: assert property (@(posedge clock) disable iff (reset)
      out_full && !rsp_pop |=> $stable(out_data))
      else $error("result queue head changed while stalled");

endmodule

// ----- hdl/mtsmr_queue.sv -----
// Small first-in first-out queue used between the front, the back and the result port.
module mtsmr_queue import mtsmr_pkg::*; #(
   parameter int  DEPTH = QUEUE_DEPTH,
   parameter type T     = mid_type
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  T     push_data,
   output logic full,
   input  logic pop,
   output T     pop_data,
   output logic empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   T                mem [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/mtsmr_front.sv -----
// Front end: derives masker thresholds and the dominant masker, then queues the band.
module mtsmr_front import mtsmr_pkg::*; #(
   parameter int NUM_BANDS   = BANDS_DEFAULT,
   parameter int NUM_MASKERS = MASKERS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic [4:0]                   band_index,
   input  logic signed [15:0]           target_db,
   input  logic [MAX_MASKERS-1:0][15:0] levels,
   input  logic signed [15:0]           offset_db,
   input  logic [MAX_MASKERS-1:0]       enable_mask,
   output logic                         mid_valid,
   input  logic                         mid_pop,
   output mid_type                      mid_data
);

   mid_type            entry;
   logic               mid_empty;
   logic signed [15:0] best;
   logic signed [15:0] th;

   always_comb begin
      entry        = '0;
      entry.last   = (band_index == 5'(NUM_BANDS - 1));
      entry.target = target_db;
      entry.dom    = -3'sd1;
      best         = DB_M100;
      th           = DB_M100;
      for (int m = 0; m < MAX_MASKERS; m++) begin
         if (m < NUM_MASKERS && enable_mask[m]) begin
            th = sat16(18'($signed(levels[m])) - 18'(offset_db));
            entry.en[m] = 1'b1;
         end else begin
            th = DB_M100;
         end
         entry.th[m] = th;
         // Strictly louder wins, so the lowest index keeps a tie.
         if (entry.en[m] && th > best) begin
            best      = th;
            entry.dom = 3'(m);
         end
      end
   end

   mtsmr_queue #(.DEPTH(QUEUE_DEPTH), .T(mid_type)) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (entry),
      .full      (full),
      .pop       (mid_pop),
      .pop_data  (mid_data),
      .empty     (mid_empty)
   );

   assign mid_valid = !mid_empty;

endmodule

// ----- hdl/mtsmr_back.sv -----
// Back end: log-add pipeline, ratio and audibility, frame totals and result queue feed.
module mtsmr_back import mtsmr_pkg::*; #(
   parameter int NUM_BANDS   = BANDS_DEFAULT,
   parameter int NUM_MASKERS = MASKERS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    mid_valid,
   input  mid_type mid_data,
   output logic    mid_pop,
   output logic    rsp_push,
   output rsp_type rsp_data,
   input  logic    rsp_full
);

   localparam int RS = 22;
   localparam logic [22:0] RECIP_BANDS = 23'(((2 ** RS) + NUM_BANDS - 1) / NUM_BANDS);

   typedef struct packed {
      mid_type            item;
      logic signed [17:0] acc;
      logic               have;
   } lane_type;

   typedef struct packed {
      logic                         last;
      logic [MAX_MASKERS-1:0][15:0] th;
      logic signed [2:0]            dom;
      logic signed [15:0]           comb;
      logic signed [15:0]           smr;
   } ratio_type;

   typedef struct packed {
      ratio_type   r;
      logic [10:0] aud;
      logic [15:0] sum;
      logic [5:0]  crit;
   } aud_type;

   logic                   en;
   lane_type               lg_ff [NUM_MASKERS];
   lane_type               lg_in [NUM_MASKERS];
   logic [NUM_MASKERS-1:0] lg_vld_ff, lg_vld_in;
   ratio_type              cs_ff, cs_in;
   logic                   cs_vld_ff;
   aud_type                ad_ff, ad_in;
   logic                   ad_vld_ff;
   logic [15:0]            sum_ff, sum_in;
   logic [5:0]             crit_ff, crit_in;
   logic signed [17:0]     num;
   logic [26:0]            aud_prod;
   logic [16:0]            sum_wide;
   logic [38:0]            mean_prod;
   logic [16:0]            mean;

   // The whole back end moves together and holds while the result queue is full.
   assign en      = !rsp_full;
   assign mid_pop = en && mid_valid;

   for (genvar k = 0; k < NUM_MASKERS; k++) begin : g_lane
      lane_type src;
      if (k == 0) begin : g_seed
         always_comb begin
            src      = '0;
            src.item = mid_data;
         end
         assign lg_vld_in[k] = mid_valid;
      end else begin : g_chain
         assign src          = lg_ff[k-1];
         assign lg_vld_in[k] = lg_vld_ff[k-1];
      end

      always_comb begin
         lg_in[k] = src;
         if (src.item.en[k]) begin
            lg_in[k].acc  = src.have ? log_add(src.acc, 18'($signed(src.item.th[k])))
                                     : 18'($signed(src.item.th[k]));
            lg_in[k].have = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            lg_ff[k] <= lg_in[k];
         end
      end
   end

   always_comb begin
      cs_in.last = lg_ff[NUM_MASKERS-1].item.last;
      cs_in.th   = lg_ff[NUM_MASKERS-1].item.th;
      cs_in.dom  = lg_ff[NUM_MASKERS-1].item.dom;
      if (!lg_ff[NUM_MASKERS-1].have || lg_ff[NUM_MASKERS-1].acc <= DB_M120) begin
         cs_in.comb = DB_M100;
      end else begin
         cs_in.comb = sat16(lg_ff[NUM_MASKERS-1].acc);
      end
      cs_in.smr = sat16(18'(lg_ff[NUM_MASKERS-1].item.target) - 18'(cs_in.comb));
   end

   always_comb begin
      num      = 18'(cs_ff.smr) + AUD_BIAS;
      aud_prod = 27'(num[12:0]) * 27'(RECIP_FIVE);
      ad_in.r  = cs_ff;
      if (num <= 18'sd0) begin
         ad_in.aud = '0;
      end else if (num >= AUD_SPAN) begin
         ad_in.aud = AUD_ONE;
      end else begin
         ad_in.aud = aud_prod[26:16];
      end
      sum_wide  = 17'(sum_ff) + 17'(ad_in.aud);
      ad_in.sum = sum_wide[16] ? 16'hFFFF : sum_wide[15:0];
      ad_in.crit = (ad_in.aud < AUD_HALF && crit_ff != 6'h3F) ? crit_ff + 1'b1 : crit_ff;
      sum_in  = sum_ff;
      crit_in = crit_ff;
      if (en && cs_vld_ff) begin
         sum_in  = cs_ff.last ? '0 : ad_in.sum;
         crit_in = cs_ff.last ? '0 : ad_in.crit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lg_vld_ff <= '0;
         cs_vld_ff <= 1'b0;
         ad_vld_ff <= 1'b0;
         sum_ff    <= '0;
         crit_ff   <= '0;
      end else begin
         sum_ff  <= sum_in;
         crit_ff <= crit_in;
         if (en) begin
            lg_vld_ff <= lg_vld_in;
            cs_vld_ff <= lg_vld_ff[NUM_MASKERS-1];
            ad_vld_ff <= cs_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cs_ff <= cs_in;
         ad_ff <= ad_in;
      end
   end

   always_comb begin
      mean_prod           = 39'(ad_ff.sum) * 39'(RECIP_BANDS);
      mean                = mean_prod[38:RS];
      rsp_data.comb       = ad_ff.r.comb;
      rsp_data.smr        = ad_ff.r.smr;
      rsp_data.aud        = ad_ff.aud;
      rsp_data.dom        = ad_ff.r.dom;
      rsp_data.th         = ad_ff.r.th;
      rsp_data.frame_done = ad_ff.r.last;
      rsp_data.overall    = '0;
      rsp_data.critical   = '0;
      if (ad_ff.r.last) begin
         rsp_data.overall  = (mean > 17'(AUD_ONE)) ? AUD_ONE : mean[10:0];
         rsp_data.critical = ad_ff.crit;
      end
   end

   assign rsp_push = en && ad_vld_ff;

endmodule
